/* src/pcpo_pkg.sv */
// Shared types and constants for the pixel color point operation block.
// Used by pcpo_weigh, pcpo_select and the top level; depends on nothing.
package pcpo_pkg;

  // Mode register codes
  localparam logic [3:0] MODE_AVG        = 4'd0;
  localparam logic [3:0] MODE_BT601      = 4'd1;
  localparam logic [3:0] MODE_BT709      = 4'd2;
  localparam logic [3:0] MODE_BINARY     = 4'd3;
  localparam logic [3:0] MODE_CHAN_THR   = 4'd4;
  localparam logic [3:0] MODE_ZERO_B     = 4'd5;
  localparam logic [3:0] MODE_ZERO_G     = 4'd6;
  localparam logic [3:0] MODE_ZERO_R     = 4'd7;
  localparam logic [3:0] MODE_ZERO_RG    = 4'd8;
  localparam logic [3:0] MODE_ZERO_RB    = 4'd9;
  localparam logic [3:0] MODE_ZERO_GB    = 4'd10;

  // Weighted sums are in units of 1/10000; max 255 * 10000 fits 22 bits
  localparam int unsigned WSUM_W = 22;
  localparam logic [WSUM_W-1:0] W601_R = 22'd2990;
  localparam logic [WSUM_W-1:0] W601_G = 22'd5870;
  localparam logic [WSUM_W-1:0] W601_B = 22'd1140;
  localparam logic [WSUM_W-1:0] W709_R = 22'd2126;
  localparam logic [WSUM_W-1:0] W709_G = 22'd7152;
  localparam logic [WSUM_W-1:0] W709_B = 22'd722;

  // floor(x / 10000) = (x * RECIP_10K) >> 37, exact for x < 2^22
  localparam int unsigned RECIP_10K_W     = 24;
  localparam int unsigned RECIP_10K_SHIFT = 37;
  localparam int unsigned PROD_10K_W      = WSUM_W + RECIP_10K_W;
  localparam logic [RECIP_10K_W-1:0] RECIP_10K = 24'd13743896;

  // floor(x / 3) = (x * 683) >> 11, exact for x < 2048
  localparam int unsigned SUM3_W        = 10;
  localparam int unsigned RECIP_3_SHIFT = 11;
  localparam int unsigned PROD_3_W      = 21;
  localparam logic [PROD_3_W-1:0] RECIP_3 = 21'd683;

  localparam logic [7:0] FULL = 8'd255;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
  } pixel_t;

  // Beat passed from the weighting stage to the select stage
  typedef struct packed {
    pixel_t              pix;
    logic [SUM3_W-1:0]   sum3;
    logic [WSUM_W-1:0]   w601;
    logic [WSUM_W-1:0]   w709;
  } sums_t;

endpackage

/* src/pcpo_weigh.sv */
// Weighting stage: channel sum and BT.601 / BT.709 weighted sums, registered.
// Depends on pcpo_pkg.
module pcpo_weigh (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  pcpo_pkg::pixel_t in_pix,
  output logic            sums_valid,
  output pcpo_pkg::sums_t sums
);
  import pcpo_pkg::*;

  logic [WSUM_W-1:0] r_ext, g_ext, b_ext;
  sums_t sums_next;

  // Form the sums with constant-coefficient products
  always_comb begin
    r_ext = WSUM_W'(in_pix.red);
    g_ext = WSUM_W'(in_pix.green);
    b_ext = WSUM_W'(in_pix.blue);
    sums_next.pix  = in_pix;
    sums_next.sum3 = SUM3_W'(in_pix.blue) + SUM3_W'(in_pix.green) + SUM3_W'(in_pix.red);
    sums_next.w601 = r_ext * W601_R + g_ext * W601_G + b_ext * W601_B;
    sums_next.w709 = r_ext * W709_R + g_ext * W709_G + b_ext * W709_B;
  end

  // Advance the beat
  always_ff @(posedge clk) begin
    if (rst) begin
      sums_valid <= 1'b0;
    end else begin
      sums_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    sums <= sums_next;
  end

endmodule

/* src/pcpo_select.sv */
// Select stage: constant divisions, thresholds and mode select into the result register.
// Depends on pcpo_pkg.
module pcpo_select (
  input  logic             clk,
  input  logic             rst,
  input  logic [3:0]       mode,
  input  logic             sums_valid,
  input  pcpo_pkg::sums_t  sums,
  output logic             res_valid,
  output pcpo_pkg::pixel_t res
);
  import pcpo_pkg::*;

  logic [PROD_3_W-1:0]   prod3;
  logic [PROD_10K_W-1:0] prod601, prod709;
  logic [7:0]            avg, g601, g709, bin;
  pixel_t                res_next;

  // Divide by constants through reciprocal products
  always_comb begin
    prod3   = PROD_3_W'(sums.sum3) * RECIP_3;
    prod601 = PROD_10K_W'(sums.w601) * PROD_10K_W'(RECIP_10K);
    prod709 = PROD_10K_W'(sums.w709) * PROD_10K_W'(RECIP_10K);
    avg     = prod3[RECIP_3_SHIFT +: 8];
    g601    = prod601[RECIP_10K_SHIFT +: 8];
    g709    = prod709[RECIP_10K_SHIFT +: 8];
    bin     = avg[7] ? FULL : 8'd0;
  end

  // Pick the result by mode; reserved codes pass the pixel through
  always_comb begin
    res_next = sums.pix;
    case (mode)
      MODE_AVG: begin
        res_next.blue = avg; res_next.green = avg; res_next.red = avg;
      end
      MODE_BT601: begin
        res_next.blue = g601; res_next.green = g601; res_next.red = g601;
      end
      MODE_BT709: begin
        res_next.blue = g709; res_next.green = g709; res_next.red = g709;
      end
      MODE_BINARY: begin
        res_next.blue = bin; res_next.green = bin; res_next.red = bin;
      end
      MODE_CHAN_THR: begin
        res_next.blue  = sums.pix.blue[7]  ? FULL : 8'd0;
        res_next.green = sums.pix.green[7] ? FULL : 8'd0;
        res_next.red   = sums.pix.red[7]   ? FULL : 8'd0;
      end
      MODE_ZERO_B: begin
        res_next.blue = 8'd0;
      end
      MODE_ZERO_G: begin
        res_next.green = 8'd0;
      end
      MODE_ZERO_R: begin
        res_next.red = 8'd0;
      end
      MODE_ZERO_RG: begin
        res_next.red = 8'd0; res_next.green = 8'd0;
      end
      MODE_ZERO_RB: begin
        res_next.red = 8'd0; res_next.blue = 8'd0;
      end
      MODE_ZERO_GB: begin
        res_next.green = 8'd0; res_next.blue = 8'd0;
      end
      default: begin
        res_next = sums.pix;
      end
    endcase
  end

  // Register the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= sums_valid;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule

/* src/pixel_color_point_operation.sv */
// Pixel color point operation: one BGRA pixel in, one pixel out, chosen by mode.
// From the accepting edge to done: input register, weighting register,
// result register, in that order. Throughput one pixel per clock; busy is
// always low and the receiver cannot stall. Synchronous active-high reset clears
// the mode register to average gray and all beat valid flags; no clearing pass.
// Depends on pcpo_pkg, pcpo_weigh and pcpo_select.
module pixel_color_point_operation (
  input  logic       clk,
  input  logic       rst,
  input  logic       mode_we,
  input  logic [3:0] mode_wdata,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] blue_in,
  input  logic [7:0] green_in,
  input  logic [7:0] red_in,
  input  logic [7:0] alpha_in,
  output logic       done,
  output logic [7:0] blue_out,
  output logic [7:0] green_out,
  output logic [7:0] red_out,
  output logic [7:0] alpha_out
);
  import pcpo_pkg::*;

  logic   [3:0] mode;
  logic         in_valid;
  pixel_t       in_pix;
  logic         sums_valid;
  sums_t        sums;
  pixel_t       res;

  assign busy = 1'b0;

  // Hold the mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_AVG;
    end else if (mode_we) begin
      mode <= mode_wdata;
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    in_pix.blue  <= blue_in;
    in_pix.green <= green_in;
    in_pix.red   <= red_in;
    in_pix.alpha <= alpha_in;
  end

  pcpo_weigh u_weigh (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_pix     (in_pix),
    .sums_valid (sums_valid),
    .sums       (sums)
  );

  pcpo_select u_select (
    .clk        (clk),
    .rst        (rst),
    .mode       (mode),
    .sums_valid (sums_valid),
    .sums       (sums),
    .res_valid  (done),
    .res        (res)
  );

  assign blue_out  = res.blue;
  assign green_out = res.green;
  assign red_out   = res.red;
  assign alpha_out = res.alpha;

endmodule

/* test/tb.sv */
// Self-checking testbench for pixel_color_point_operation: per-pixel mode ops.
// Depends on pcpo_pkg (pixel_t, mode codes) and the block's RTL under src/.
`timescale 1ns / 100ps

module tb;
  import pcpo_pkg::*;

  localparam int unsigned LATENCY       = 3;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned GAP_PCT       = 32;
  localparam int unsigned PHASES        = 20;
  localparam int unsigned PIX_PER_PHASE = 95;

  // Gray weights in units of 1/10000
  localparam int unsigned WT_DEN   = 10000;
  localparam int unsigned BT601_WR = 2990;
  localparam int unsigned BT601_WG = 5870;
  localparam int unsigned BT601_WB = 1140;
  localparam int unsigned BT709_WR = 2126;
  localparam int unsigned BT709_WG = 7152;
  localparam int unsigned BT709_WB = 722;
  localparam int unsigned LEVEL_THRESH = 128;

  // Codes past the last defined mode pass the pixel through
  localparam logic [3:0] MODE_RESERVED_LO = 4'd11;
  localparam logic [3:0] MODE_RESERVED_HI = 4'd15;

  typedef enum logic [1:0] {ITEM_PIXEL, ITEM_MODE, ITEM_DRAIN} item_kind_t;

  typedef struct {
    item_kind_t kind;
    pixel_t     pix;
    logic [3:0] mode;
    bit         no_gap;
  } stim_item_t;

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       mode_we    = 1'b0;
  logic [3:0] mode_wdata = MODE_AVG;
  logic       start      = 1'b0;
  logic       busy;
  logic [7:0] blue_in    = 8'd0;
  logic [7:0] green_in   = 8'd0;
  logic [7:0] red_in     = 8'd0;
  logic [7:0] alpha_in   = 8'd0;
  logic       done;
  logic [7:0] blue_out;
  logic [7:0] green_out;
  logic [7:0] red_out;
  logic [7:0] alpha_out;

  stim_item_t  pending_q[$];
  pixel_t      expected_pix_q[$];
  logic [3:0]  mode_shadow  = MODE_AVG;
  int unsigned quiet_cycles = 0;
  int unsigned cycle_count  = 0;
  int unsigned error_count  = 0;
  bit          stim_done    = 1'b0;

  pixel_color_point_operation u_top (
    .clk        (clk),
    .rst        (rst),
    .mode_we    (mode_we),
    .mode_wdata (mode_wdata),
    .start      (start),
    .busy       (busy),
    .blue_in    (blue_in),
    .green_in   (green_in),
    .red_in     (red_in),
    .alpha_in   (alpha_in),
    .done       (done),
    .blue_out   (blue_out),
    .green_out  (green_out),
    .red_out    (red_out),
    .alpha_out  (alpha_out)
  );

  // Clock and single reset pulse
  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic logic [7:0] level(input int unsigned v);
    return (v >= LEVEL_THRESH) ? 8'd255 : 8'd0;
  endfunction

  // Expected output pixel for one input pixel under the given mode
  function automatic pixel_t point_op(input logic [3:0] mode, input pixel_t px);
    pixel_t      q;
    int unsigned b, g, r, gray;
    q = px;
    b = 32'(px.blue);
    g = 32'(px.green);
    r = 32'(px.red);
    gray = 0;
    case (mode)
      MODE_AVG:    gray = (b + g + r) / 3;
      MODE_BT601:  gray = (r * BT601_WR + g * BT601_WG + b * BT601_WB) / WT_DEN;
      MODE_BT709:  gray = (r * BT709_WR + g * BT709_WG + b * BT709_WB) / WT_DEN;
      MODE_BINARY: gray = 32'(level((b + g + r) / 3));
      MODE_CHAN_THR: begin
        q.blue  = level(b);
        q.green = level(g);
        q.red   = level(r);
      end
      MODE_ZERO_B:  q.blue = 8'd0;
      MODE_ZERO_G:  q.green = 8'd0;
      MODE_ZERO_R:  q.red = 8'd0;
      MODE_ZERO_RG: begin
        q.red   = 8'd0;
        q.green = 8'd0;
      end
      MODE_ZERO_RB: begin
        q.red  = 8'd0;
        q.blue = 8'd0;
      end
      MODE_ZERO_GB: begin
        q.green = 8'd0;
        q.blue  = 8'd0;
      end
      default: ;
    endcase
    // Gray modes write one value to all three colors
    if (mode == MODE_AVG || mode == MODE_BT601 || mode == MODE_BT709 ||
        mode == MODE_BINARY) begin
      q.blue  = 8'(gray);
      q.green = 8'(gray);
      q.red   = 8'(gray);
    end
    return q;
  endfunction

  // Stimulus queue helpers
  task automatic push_pixel(input int unsigned b, g, r, a, input bit no_gap);
    stim_item_t it;
    it.kind   = ITEM_PIXEL;
    it.pix    = '{blue: 8'(b), green: 8'(g), red: 8'(r), alpha: 8'(a)};
    it.mode   = MODE_AVG;
    it.no_gap = no_gap;
    pending_q = {pending_q, it};
  endtask

  task automatic push_mode(input logic [3:0] m);
    stim_item_t it;
    it.kind   = ITEM_MODE;
    it.pix    = '0;
    it.mode   = m;
    it.no_gap = 1'b0;
    pending_q = {pending_q, it};
  endtask

  task automatic push_drain();
    stim_item_t it;
    it.kind   = ITEM_DRAIN;
    it.pix    = '0;
    it.mode   = MODE_AVG;
    it.no_gap = 1'b0;
    pending_q = {pending_q, it};
  endtask

  // Channel value leaning toward the extremes and the threshold edge
  function automatic int unsigned rand_chan();
    case ($urandom_range(7))
      0:       return 0;
      1:       return 255;
      2:       return $urandom_range(129, 127);
      default: return $urandom_range(255);
    endcase
  endfunction

  // Fill the stimulus: directed corners, then random phases
  initial begin
    logic [3:0] m;
    bit         steady;
    // Average gray straight out of reset
    push_pixel(0, 0, 0, 0, 1'b0);
    push_pixel(255, 255, 255, 255, 1'b0);
    push_pixel(1, 2, 2, 8'h5a, 1'b0);
    push_mode(MODE_BT601);
    push_pixel(255, 255, 255, 8'ha5, 1'b0);
    push_pixel(0, 0, 255, 0, 1'b0);
    push_mode(MODE_BT709);
    push_pixel(255, 255, 255, 1, 1'b0);
    push_pixel(255, 0, 0, 254, 1'b0);
    // Binary threshold right at the average of 128
    push_mode(MODE_BINARY);
    push_pixel(128, 128, 128, 7, 1'b0);
    push_pixel(127, 128, 128, 7, 1'b0);
    push_mode(MODE_CHAN_THR);
    push_pixel(127, 128, 255, 128, 1'b0);
    push_mode(MODE_ZERO_B);
    push_pixel(255, 255, 255, 255, 1'b0);
    push_mode(MODE_ZERO_G);
    push_pixel(255, 255, 255, 255, 1'b0);
    push_mode(MODE_ZERO_R);
    push_pixel(255, 255, 255, 255, 1'b0);
    push_mode(MODE_ZERO_RG);
    push_pixel(255, 255, 255, 255, 1'b0);
    push_mode(MODE_ZERO_RB);
    push_pixel(255, 255, 255, 255, 1'b0);
    push_mode(MODE_ZERO_GB);
    push_pixel(255, 255, 255, 255, 1'b0);
    // Reserved codes pass the pixel through
    push_mode(MODE_RESERVED_LO);
    push_pixel(12, 200, 99, 3, 1'b0);
    push_mode(MODE_RESERVED_HI);
    push_pixel(255, 0, 128, 77, 1'b0);

    // Random phases: sweep every code once, then random codes
    for (int p = 0; p < PHASES; p++) begin
      m = (p < 16) ? 4'(p) : 4'($urandom_range(15));
      steady = (p == 8 || p == 9);
      push_mode(m);
      for (int i = 0; i < PIX_PER_PHASE; i++) begin
        if ((p == 5 || p == 12) && i == PIX_PER_PHASE / 2) push_drain();
        push_pixel(rand_chan(), rand_chan(), rand_chan(), $urandom_range(255), steady);
      end
    end
    push_mode(MODE_AVG);
    push_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255),
               $urandom_range(255), 1'b0);
  end

  // Driver: record accepted beats, then launch the next pending item
  always @(posedge clk) begin
    stim_item_t it;
    logic       start_nxt;
    logic       we_nxt;
    start_nxt = 1'b0;
    we_nxt    = 1'b0;
    if (rst) begin
      start   <= 1'b0;
      mode_we <= 1'b0;
      quiet_cycles = 0;
    end else begin
      if (start && !busy) begin
        expected_pix_q = {expected_pix_q,
          point_op(mode_shadow, pixel_t'({blue_in, green_in, red_in, alpha_in}))};
      end
      if (start && busy) begin
        start_nxt = 1'b1;
      end else if (pending_q.size() > 0) begin
        it = pending_q[0];
        case (it.kind)
          ITEM_PIXEL: begin
            if (it.no_gap || $urandom_range(99) >= GAP_PCT) begin
              start_nxt = 1'b1;
              blue_in  <= it.pix.blue;
              green_in <= it.pix.green;
              red_in   <= it.pix.red;
              alpha_in <= it.pix.alpha;
              void'(pending_q.pop_front());
            end
          end
          ITEM_MODE: begin
            // Write mode only with the pipeline empty and settled
            if (expected_pix_q.size() == 0 && quiet_cycles > LATENCY) begin
              we_nxt = 1'b1;
              mode_wdata <= it.mode;
              mode_shadow = it.mode;
              void'(pending_q.pop_front());
            end
          end
          default: begin
            // Hold off until every outstanding result has come back
            if (expected_pix_q.size() == 0) void'(pending_q.pop_front());
          end
        endcase
      end else begin
        stim_done = 1'b1;
      end
      start   <= start_nxt;
      mode_we <= we_nxt;
      if (expected_pix_q.size() == 0 && !start_nxt) quiet_cycles++;
      else quiet_cycles = 0;
    end
  end

  // Monitor: compare each result beat with the oldest expected pixel
  always @(posedge clk) begin
    pixel_t want;
    pixel_t got;
    string  chan_name[4];
    chan_name = '{"blue", "green", "red", "alpha"};
    if (!rst) begin
      got = pixel_t'({blue_out, green_out, red_out, alpha_out});
      if ($isunknown(done)) begin
        $display("%0t: done is unknown", $time);
        error_count++;
      end else if (done) begin
        if (expected_pix_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          error_count++;
        end else begin
          want = expected_pix_q.pop_front();
          for (int i = 0; i < 4; i++) begin
            if (got[31-8*i -: 8] !== want[31-8*i -: 8]) begin
              $display("%0t: %s expected %0d actual %0d", $time, chan_name[i],
                       want[31-8*i -: 8], got[31-8*i -: 8]);
              error_count++;
            end
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("pixel_color_point_operation: mismatch");
      $finish;
    end
  end

  // End of run: drain, settle, report
  initial begin
    @(negedge rst);
    while (!(stim_done && expected_pix_q.size() == 0)) @(posedge clk);
    repeat (4 * LATENCY) @(posedge clk);
    if (error_count == 0 && expected_pix_q.size() == 0) begin
      $display("pixel_color_point_operation: match");
    end else begin
      $display("pixel_color_point_operation: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/pcpo_pkg.sv
src/pcpo_weigh.sv
src/pcpo_select.sv
src/pixel_color_point_operation.sv
test/tb.sv
